[hdl/sctc_pkg.sv]
// Shared types, constants and helper functions of the sector cache tag controller.
package sctc_pkg;

  localparam int ENTRIES     = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int SLOT_W      = 6;
  localparam int SECTOR_W    = 32;
  localparam int OP_W        = 2;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int IN_TDATA_W  = 8 * ((OP_W + SECTOR_W + 7) / 8);
  localparam int OUT_TDATA_W = 8 * ((SLOT_W + SECTOR_W + 7) / 8);
  localparam int OUT_PAD_W   = OUT_TDATA_W - SLOT_W - SECTOR_W;
  localparam int OUT_TUSER_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_RSVD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FL_SEEK,
    ST_FL_EMIT
  } state_t;

  typedef struct packed {
    logic capture;        // latch access word and tag match vector
    logic access_commit;  // update entry state and load access result
    logic flush_start;    // clear writeback count
    logic seek_load;      // latch next dirty slot and start its tag read
    logic flush_emit;     // load writeback result and clear its dirty mark
    logic flush_empty;    // load the single result of a clean flush
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic out_free;
    logic pend_any;
    logic more;
  } status_t;

  // isolate the lowest set bit
  function automatic logic [ENTRIES-1:0] lowest_oh(input logic [ENTRIES-1:0] v);
    return v & (~v + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] oh_to_idx(input logic [ENTRIES-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[hdl/sctc_ctrl.sv]
// Control state machine: sequences lookups and flush walks.
module sctc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sctc_pkg::status_t status,
  output sctc_pkg::cmd_t    cmd
);
  import sctc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (status.in_op)
            OP_READ, OP_WRITE: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_LOOKUP;
            end
            OP_FLUSH: begin
              cmd.flush_start = 1'b1;
              state_nxt       = ST_FL_SEEK;
            end
            default: begin
              // reserved code: drop the word
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (status.out_free) begin
          cmd.access_commit = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_FL_SEEK: begin
        if (status.pend_any) begin
          cmd.seek_load = 1'b1;
          state_nxt     = ST_FL_EMIT;
        end else if (status.out_free) begin
          cmd.flush_empty = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_FL_EMIT: begin
        if (status.out_free) begin
          cmd.flush_emit = 1'b1;
          state_nxt      = status.more ? ST_FL_SEEK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/sctc_dp.sv]
// Datapath: tag store, valid and dirty marks, victim pointer and result register.
module sctc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sctc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  sctc_pkg::cmd_t                      cmd,
  output sctc_pkg::status_t                   status,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sctc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [sctc_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast
);
  import sctc_pkg::*;

  // compare copy of the tags, one register per entry
  logic [SECTOR_W-1:0] tag_r [ENTRIES];
  // indexed copy of the tags for victim and flush reads
  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W-1:0] rd_data_r;
  logic [IDX_W-1:0]    rd_addr;

  logic [ENTRIES-1:0]  valid_r, dirty_r, match_r;
  logic [ENTRIES-1:0]  pend, hit_oh, free_oh, pend_oh;
  logic [SECTOR_W-1:0] in_sector, sector_r;
  op_t                 op_r;

  logic [IDX_W-1:0]    vp_r, vp_nxt, hit_idx, free_idx, pend_idx, acc_slot, fl_idx_r;
  logic                hit, any_free, victim_wb, more_r, more_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic                out_valid_r, out_hit_r, out_fill_r, out_wb_r, out_last_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [SECTOR_W-1:0] out_wbsec_r;
  logic                out_load;

  assign in_sector = in_tdata[OP_W +: SECTOR_W];

  // access decision
  assign hit_oh    = lowest_oh(match_r);
  assign hit_idx   = oh_to_idx(hit_oh);
  assign hit       = |match_r;
  assign free_oh   = lowest_oh(~valid_r);
  assign free_idx  = oh_to_idx(free_oh);
  assign any_free  = |(~valid_r);
  assign acc_slot  = hit ? hit_idx : (any_free ? free_idx : vp_r);
  assign victim_wb = !hit && !any_free && dirty_r[vp_r];
  assign vp_nxt    = (vp_r == IDX_W'(ENTRIES - 1)) ? '0 : vp_r + 1'b1;

  // flush walk
  assign pend     = valid_r & dirty_r;
  assign pend_oh  = lowest_oh(pend);
  assign pend_idx = oh_to_idx(pend_oh);
  assign more_nxt = (|(pend & ~pend_oh)) && (cnt_r < CNT_W'(MAX_RESULTS - 1));
  assign cnt_nxt  = cmd.flush_start ? '0 : (cmd.seek_load ? cnt_r + 1'b1 : cnt_r);

  assign rd_addr  = cmd.seek_load ? pend_idx : vp_r;
  assign out_load = cmd.access_commit | cmd.flush_emit | cmd.flush_empty;

  assign status.in_op    = op_t'(in_tdata[OP_W-1:0]);
  assign status.out_free = !out_valid_r || out_tready;
  assign status.pend_any = |pend;
  assign status.more     = more_r;

  always_ff @(posedge clk) begin
    if (cmd.access_commit && !hit) begin
      tag_mem[acc_slot] <= sector_r;
    end
    // hold the read word until the lookup or writeback that uses it
    if (cmd.capture || cmd.seek_load) begin
      rd_data_r <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access_commit && !hit) begin
      tag_r[acc_slot] <= sector_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sector_r <= in_sector;
      op_r     <= status.in_op;
      for (int i = 0; i < ENTRIES; i++) begin
        match_r[i] <= valid_r[i] && (tag_r[i] == in_sector);
      end
    end
    if (cmd.seek_load) begin
      fl_idx_r <= pend_idx;
      more_r   <= more_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
      vp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.access_commit) begin
        if (!hit) begin
          valid_r[acc_slot] <= 1'b1;
        end
        dirty_r[acc_slot] <= (op_r == OP_WRITE) || (hit && dirty_r[acc_slot]);
        if (!hit && !any_free) begin
          vp_r <= vp_nxt;
        end
      end
      if (cmd.flush_emit) begin
        dirty_r[fl_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access_commit) begin
      out_slot_r  <= SLOT_W'(acc_slot);
      out_hit_r   <= hit;
      out_fill_r  <= !hit;
      out_wb_r    <= victim_wb;
      out_wbsec_r <= victim_wb ? rd_data_r : '0;
      out_last_r  <= 1'b1;
    end else if (cmd.flush_emit) begin
      out_slot_r  <= SLOT_W'(fl_idx_r);
      out_hit_r   <= 1'b0;
      out_fill_r  <= 1'b0;
      out_wb_r    <= 1'b1;
      out_wbsec_r <= rd_data_r;
      out_last_r  <= !more_r;
    end else if (cmd.flush_empty) begin
      out_slot_r  <= '0;
      out_hit_r   <= 1'b0;
      out_fill_r  <= 1'b0;
      out_wb_r    <= 1'b0;
      out_wbsec_r <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_wbsec_r, out_slot_r};
  assign out_tuser  = {out_wb_r, out_fill_r, out_hit_r};
  assign out_tlast  = out_last_r;

endmodule

[hdl/sector_cache_tag_controller_top.sv]
// Top level of the sector cache tag controller.
// Tag and replacement logic of a fully associative, write-back cache of disk
// sectors. The in_ stream carries one request word: read, write or flush.
// The out_ stream returns result words: slot, hit, fill and writeback flags,
// and the sector to write back; tlast marks the final word of a request.
// Read or write: exactly one result word. A parallel compare against all
// tags is latched on accept; the slot is then chosen and the result word
// loaded once the result register is free, and no new request is taken
// until that word is loaded.
// Flush: one word per valid dirty slot, lowest slot first; each word takes
// a dirty search and tag store read, then a result load; a clean cache
// gives one empty word with tlast set.
// The result register lets the next request enter while a word waits; when
// out_tready is low the block holds the word and stalls before the next one.
// Reset clears all valid and dirty marks and the round-robin victim pointer;
// the block takes requests in the first cycle after reset.
module sector_cache_tag_controller_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sctc_pkg::IN_TDATA_W-1:0]  in_tdata,   // op, sector
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sctc_pkg::OUT_TDATA_W-1:0] out_tdata,  // slot, writeback_sector
  output logic [sctc_pkg::OUT_TUSER_W-1:0] out_tuser,  // hit, fill_needed, writeback_needed
  output logic                             out_tlast
);
  import sctc_pkg::*;

  cmd_t    cmd;
  status_t status;

  sctc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sctc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[hdl/sctc_checker.sv]
// Port-level checks of the sector cache tag controller, bound to the top level.
module sctc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [sctc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sctc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [sctc_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic                             out_tlast
);
  import sctc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // an accepted request keeps the input closed for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[OP_W-1:0] != OP_RSVD) |=> !in_tready)
    else $error("request accepted back to back");

  // no request is taken while a flush still has words to deliver
  a_flush_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open during flush");

  // a hit is a single word with no writeback sector
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata[37:6] == 32'd0))
    else $error("hit word carries writeback data");

endmodule

bind sector_cache_tag_controller_top sctc_checker u_sctc_checker (.*);

[tb/tb_sector_cache_tag_controller_top.sv]
// Self-checking testbench for the sector cache tag controller: lookup, allocation, eviction and flush.
`timescale 1ns / 1ps

module tb_sector_cache_tag_controller_top;
  import sctc_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill;
    logic                wb;
    logic [SECTOR_W-1:0] wb_sector;
    logic                last;
  } cache_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  sector_cache_tag_controller_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow copy of the tag store and replacement state
  logic [SECTOR_W-1:0] shadow_tag   [ENTRIES];
  logic                shadow_valid [ENTRIES];
  logic                shadow_dirty [ENTRIES];
  logic [IDX_W-1:0]    shadow_victim;

  cache_result_t pending_results[$];

  int idle_pct;
  int stall_pct;
  int mismatches;
  int words_sent;
  int words_checked;
  int hits_seen;
  int misses_seen;
  int writebacks_seen;
  int flushes_sent;

  logic [SECTOR_W-1:0] sector_pool [256];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // work out the result words of one accepted request and update the shadow state
  task automatic predict_request(input op_t op, input logic [SECTOR_W-1:0] sector);
    cache_result_t r;
    int            n;
    int            slot;
    bit            found;
    bit            freed;
    r = '0;
    n = 0;
    slot = 0;
    found = 0;
    freed = 0;
    if (op == OP_FLUSH) begin
      flushes_sent++;
      for (int i = 0; i < ENTRIES && n < MAX_RESULTS; i++) begin
        if (shadow_valid[i] && shadow_dirty[i]) begin
          r = '0;
          r.slot = SLOT_W'(i);
          r.wb = 1'b1;
          r.wb_sector = shadow_tag[i];
          r.last = 1'b0;
          shadow_dirty[i] = 1'b0;
          pending_results.push_back(r);
          n++;
        end
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        pending_results.push_back(r);
      end else begin
        pending_results[pending_results.size() - 1].last = 1'b1;
      end
    end else if (op == OP_READ || op == OP_WRITE) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!found && shadow_valid[i] && shadow_tag[i] == sector) begin
          found = 1;
          slot = i;
        end
      end
      if (!found) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!freed && !shadow_valid[i]) begin
            freed = 1;
            slot = i;
          end
        end
        if (!freed) begin
          slot = int'(shadow_victim);
          if (shadow_dirty[slot]) begin
            r.wb = 1'b1;
            r.wb_sector = shadow_tag[slot];
          end
          shadow_victim = shadow_victim + 1'b1;
        end
        shadow_tag[slot] = sector;
        shadow_valid[slot] = 1'b1;
        shadow_dirty[slot] = 1'b0;
      end
      if (op == OP_WRITE) begin
        shadow_dirty[slot] = 1'b1;
      end
      r.slot = SLOT_W'(slot);
      r.hit = found;
      r.fill = !found;
      r.last = 1'b1;
      pending_results.push_back(r);
    end
    // reserved op: no state change, no words
  endtask

  task automatic send_request(input op_t op, input logic [SECTOR_W-1:0] sector);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - OP_W - SECTOR_W){1'b0}}, sector, op};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    predict_request(op, sector);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cache_result_t want;
    cache_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.slot = out_tdata[SLOT_W-1:0];
      got.wb_sector = out_tdata[SLOT_W +: SECTOR_W];
      got.hit = out_tuser[0];
      got.fill = out_tuser[1];
      got.wb = out_tuser[2];
      got.last = out_tlast;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word slot=%0d hit=%0b fill=%0b wb=%0b wb_sector=%h last=%0b",
                 $time, got.slot, got.hit, got.fill, got.wb, got.wb_sector, got.last);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (got.hit) hits_seen++;
        if (got.fill) misses_seen++;
        if (got.wb) writebacks_seen++;
        if (got !== want) begin
          mismatches++;
          if (got.slot !== want.slot)
            $display("%0t: slot expected %0d got %0d", $time, want.slot, got.slot);
          if (got.hit !== want.hit)
            $display("%0t: hit expected %0b got %0b", $time, want.hit, got.hit);
          if (got.fill !== want.fill)
            $display("%0t: fill_needed expected %0b got %0b", $time, want.fill, got.fill);
          if (got.wb !== want.wb)
            $display("%0t: writeback_needed expected %0b got %0b", $time, want.wb, got.wb);
          if (got.wb_sector !== want.wb_sector)
            $display("%0t: writeback_sector expected %h got %h", $time,
                     want.wb_sector, got.wb_sector);
          if (got.last !== want.last)
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
        end
      end
    end
  end

  // corner sectors, every op, clean and dirty flushes, reserved op
  task automatic test_directed_corners;
    idle_pct = 0;
    stall_pct = 0;
    send_request(OP_FLUSH, 32'h0);
    send_request(OP_RSVD, 32'h1234_5678);
    send_request(OP_READ, 32'h0000_0000);
    send_request(OP_WRITE, 32'hFFFF_FFFF);
    send_request(OP_READ, 32'hFFFF_FFFF);
    send_request(OP_WRITE, 32'h0000_0000);
    send_request(OP_READ, 32'h8000_0000);
    send_request(OP_READ, 32'h0000_0001);
    send_request(OP_WRITE, 32'h5555_5555);
    send_request(OP_READ, 32'hAAAA_AAAA);
    send_request(OP_RSVD, 32'h0);
    send_request(OP_FLUSH, 32'hFFFF_FFFF);
    send_request(OP_FLUSH, 32'h0);
    send_request(OP_WRITE, 32'h7FFF_FFFF);
    send_request(OP_READ, 32'h7FFF_FFFF);
    send_request(OP_WRITE, 32'hAAAA_AAAA);
    send_request(OP_FLUSH, 32'h0);
  endtask

  // mixed traffic over a working set; a larger set forces round-robin eviction
  task automatic test_traffic(input int count, input int idle, input int stall,
                              input int set_size);
    int                  pick;
    op_t                 op;
    logic [SECTOR_W-1:0] sector;
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < set_size; i++) begin
      sector_pool[i] = $urandom;
    end
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 44) op = OP_READ;
      else if (pick < 88) op = OP_WRITE;
      else if (pick < 94) op = OP_FLUSH;
      else op = OP_RSVD;
      if ($urandom_range(9) == 0) sector = $urandom;
      else sector = sector_pool[$urandom_range(set_size - 1)];
      send_request(op, sector);
    end
  endtask

  // dirty every slot with fresh sectors, then flush the lot
  task automatic test_full_dirty_flush;
    idle_pct = 37;
    stall_pct = 37;
    send_request(OP_FLUSH, 32'h0);
    for (int i = 0; i < ENTRIES; i++) begin
      send_request(OP_WRITE, $urandom);
    end
    send_request(OP_FLUSH, 32'h0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    hits_seen = 0;
    misses_seen = 0;
    writebacks_seen = 0;
    flushes_sent = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_tag[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
    end
    shadow_victim = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_traffic(100, 0, 0, 40);
    test_traffic(100, 68, 0, 100);
    test_traffic(100, 0, 68, 70);
    test_traffic(100, 37, 37, 200);
    test_full_dirty_flush();

    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests (%0d flushes), checked %0d result words.",
             words_sent, flushes_sent, words_checked);
    $display("Hits %0d, misses %0d, writebacks %0d, mismatches %0d.",
             hits_seen, misses_seen, writebacks_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hdl/sctc_pkg.sv
hdl/sctc_ctrl.sv
hdl/sctc_dp.sv
hdl/sector_cache_tag_controller_top.sv
hdl/sctc_checker.sv
tb/tb_sector_cache_tag_controller_top.sv
